>>> src/ip_route_table_defines.svh
// assertion macros shared by the ip_route_table rtl
// no dependencies; included by files that carry concurrent checks
`ifndef IP_ROUTE_TABLE_DEFINES_SVH
`define IP_ROUTE_TABLE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define IRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("irt check failed");

// next-cycle implication, disabled while reset is asserted
`define IRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("irt check failed");

`endif

>>> src/irt_pkg.sv
// shared types and constants of the ip route table
// no dependencies; used by irt_ctrl, irt_datapath and ip_route_table
`default_nettype none

package irt_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned WORD_W = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    ACT_UPDATE       = 2'd0,
    ACT_REMOVE       = 2'd1,
    ACT_LOOKUP_NET   = 2'd2,
    ACT_LOOKUP_IFACE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    word_t data;
    word_t iface;
    word_t mask;
    word_t network;
  } route_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic rd_en;
    idx_t rd_addr;
    logic cmp_en;
    logic commit;
    logic fetch;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic lookup_hit;
  } dp_status_t;

endpackage

`default_nettype wire

>>> src/irt_datapath.sv
// route table storage, scan comparators, hit trackers and result register
// depends on irt_pkg; driven by irt_ctrl through dp_cmd_t
`default_nettype none

module irt_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire irt_pkg::dp_cmd_t    cmd_i,
  output irt_pkg::dp_status_t      status_o,
  input  wire irt_pkg::action_e    req_action_i,
  input  wire irt_pkg::word_t      req_net_i,
  input  wire irt_pkg::word_t      req_mask_i,
  input  wire irt_pkg::word_t      req_iface_i,
  input  wire irt_pkg::word_t      req_data_i,
  output irt_pkg::status_e         res_status_o,
  output irt_pkg::route_t          res_route_o
);

  // request registers
  irt_pkg::action_e act_q;
  irt_pkg::word_t   net_q, mask_q, iface_q, data_q;

  // table storage
  irt_pkg::route_t  mem_q [irt_pkg::TABLE_DEPTH];
  logic             valid_q [irt_pkg::TABLE_DEPTH];
  irt_pkg::route_t  rd_data_q;
  irt_pkg::idx_t    rd_idx_q;
  irt_pkg::idx_t    rd_addr;
  logic             rd_en;

  // scan trackers
  logic exact_hit_q, mask_hit_q, zero_hit_q, ifc_hit_q, free_hit_q;
  irt_pkg::idx_t exact_idx_q, mask_idx_q, zero_idx_q, ifc_idx_q, free_idx_q;
  irt_pkg::word_t mask_net_q, ifc_net_q;

  // resolved outcome
  logic             hit_q;
  irt_pkg::idx_t    hit_idx_q;
  irt_pkg::status_e res_status_q;

  // output register
  irt_pkg::status_e out_status_q;
  irt_pkg::route_t  out_route_q;

  logic e_valid;
  logic m_exact, m_mask, m_zero, m_ifc, m_free;
  logic upd_ok, lk_hit;
  irt_pkg::idx_t upd_idx, lk_idx;
  irt_pkg::status_e res_status;

  assign rd_en   = cmd_i.rd_en | cmd_i.fetch;
  assign rd_addr = cmd_i.fetch ? hit_idx_q : cmd_i.rd_addr;

  // per-entry compare on the registered read data
  always_comb begin
    e_valid = valid_q[rd_idx_q];
    m_exact = e_valid && (rd_data_q.network == net_q);
    m_zero  = e_valid && (rd_data_q.network == '0);
    m_mask  = e_valid && (rd_data_q.network == (net_q & rd_data_q.mask)) &&
              (!mask_hit_q || (rd_data_q.network < mask_net_q));
    m_ifc   = e_valid && (rd_data_q.iface == iface_q) &&
              (!ifc_hit_q || (rd_data_q.network < ifc_net_q));
    m_free  = !e_valid && !free_hit_q;
  end

  // choose the outcome once the scan is done
  always_comb begin
    upd_ok     = exact_hit_q | free_hit_q;
    upd_idx    = exact_hit_q ? exact_idx_q : free_idx_q;
    lk_hit     = 1'b0;
    lk_idx     = exact_idx_q;
    res_status = irt_pkg::STAT_OK;
    case (act_q)
      irt_pkg::ACT_UPDATE: begin
        if (!upd_ok) res_status = irt_pkg::STAT_FULL;
      end
      irt_pkg::ACT_REMOVE: begin
        if (!exact_hit_q) res_status = irt_pkg::STAT_NOT_FOUND;
      end
      irt_pkg::ACT_LOOKUP_NET: begin
        if (exact_hit_q) begin
          lk_hit = 1'b1;
          lk_idx = exact_idx_q;
        end else if (mask_hit_q) begin
          lk_hit = 1'b1;
          lk_idx = mask_idx_q;
        end else if (zero_hit_q) begin
          lk_hit = 1'b1;
          lk_idx = zero_idx_q;
        end
        if (!lk_hit) res_status = irt_pkg::STAT_NOT_FOUND;
      end
      irt_pkg::ACT_LOOKUP_IFACE: begin
        lk_hit = ifc_hit_q;
        lk_idx = ifc_idx_q;
        if (!lk_hit) res_status = irt_pkg::STAT_NOT_FOUND;
      end
      default: begin
        res_status = irt_pkg::STAT_NOT_FOUND;
      end
    endcase
  end

  assign status_o.lookup_hit = lk_hit;

  // request payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      act_q   <= req_action_i;
      net_q   <= req_net_i;
      mask_q  <= req_mask_i;
      iface_q <= req_iface_i;
      data_q  <= req_data_i;
    end
  end

  // route memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && (act_q == irt_pkg::ACT_UPDATE) && upd_ok) begin
      mem_q[upd_idx] <= '{data: data_q, iface: iface_q, mask: mask_q, network: net_q};
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_idx_q  <= rd_addr;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < irt_pkg::TABLE_DEPTH; i++) valid_q[i] <= 1'b0;
    end else if (cmd_i.commit) begin
      if ((act_q == irt_pkg::ACT_UPDATE) && upd_ok) valid_q[upd_idx] <= 1'b1;
      if ((act_q == irt_pkg::ACT_REMOVE) && exact_hit_q) valid_q[exact_idx_q] <= 1'b0;
    end
  end

  // scan trackers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exact_hit_q <= 1'b0;
      mask_hit_q  <= 1'b0;
      zero_hit_q  <= 1'b0;
      ifc_hit_q   <= 1'b0;
      free_hit_q  <= 1'b0;
      exact_idx_q <= '0;
      mask_idx_q  <= '0;
      zero_idx_q  <= '0;
      ifc_idx_q   <= '0;
      free_idx_q  <= '0;
      mask_net_q  <= '0;
      ifc_net_q   <= '0;
    end else if (cmd_i.load_req) begin
      exact_hit_q <= 1'b0;
      mask_hit_q  <= 1'b0;
      zero_hit_q  <= 1'b0;
      ifc_hit_q   <= 1'b0;
      free_hit_q  <= 1'b0;
    end else if (cmd_i.cmp_en) begin
      if (m_exact) begin
        exact_hit_q <= 1'b1;
        exact_idx_q <= rd_idx_q;
      end
      if (m_zero) begin
        zero_hit_q <= 1'b1;
        zero_idx_q <= rd_idx_q;
      end
      if (m_mask) begin
        mask_hit_q <= 1'b1;
        mask_idx_q <= rd_idx_q;
        mask_net_q <= rd_data_q.network;
      end
      if (m_ifc) begin
        ifc_hit_q <= 1'b1;
        ifc_idx_q <= rd_idx_q;
        ifc_net_q <= rd_data_q.network;
      end
      if (m_free) begin
        free_hit_q <= 1'b1;
        free_idx_q <= rd_idx_q;
      end
    end
  end

  // resolved outcome
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q        <= 1'b0;
      hit_idx_q    <= '0;
      res_status_q <= irt_pkg::STAT_OK;
    end else if (cmd_i.commit) begin
      hit_q        <= lk_hit;
      hit_idx_q    <= lk_idx;
      res_status_q <= res_status;
    end
  end

  // result register, zero fields unless a lookup hit
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_route_q  <= hit_q ? rd_data_q : '0;
    end
  end

  assign res_status_o = out_status_q;
  assign res_route_o  = out_route_q;

endmodule

`default_nettype wire

>>> src/irt_ctrl.sv
// sequencer of the route table: accept, scan, resolve, fetch, hand off
// depends on irt_pkg and ip_route_table_defines.svh
`default_nettype none
`include "ip_route_table_defines.svh"

module irt_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_tvalid_i,
  output logic                    s_tready_o,
  output logic                    m_tvalid_o,
  input  wire logic               m_tready_i,
  output irt_pkg::dp_cmd_t        cmd_o,
  input  wire irt_pkg::dp_status_t status_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESOLVE,
    ST_FETCH,
    ST_FINISH
  } state_e;

  state_e        state_q;
  irt_pkg::idx_t cnt_q;
  logic          m_valid_q;
  logic          in_fire, cnt_last, out_free, out_load;

  assign in_fire  = s_tvalid_i && (state_q == ST_IDLE);
  assign cnt_last = (cnt_q == irt_pkg::IDX_W'(irt_pkg::TABLE_DEPTH - 1));
  assign out_free = !m_valid_q || m_tready_i;
  assign out_load = (state_q == ST_FINISH) && out_free;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load_req = in_fire;
    cmd_o.rd_en    = (state_q == ST_SCAN);
    cmd_o.rd_addr  = cnt_q;
    // compare runs in the cycle after its read is issued
    cmd_o.cmp_en   = ((state_q == ST_SCAN) && (cnt_q != '0)) || (state_q == ST_DRAIN);
    cmd_o.commit   = (state_q == ST_RESOLVE);
    cmd_o.fetch    = (state_q == ST_FETCH);
    cmd_o.out_load = out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      // a new result replaces the one taken in the same cycle
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_SCAN;
            cnt_q   <= '0;
          end
        end
        ST_SCAN: begin
          if (cnt_last) begin
            state_q <= ST_DRAIN;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_RESOLVE;
        end
        ST_RESOLVE: begin
          state_q <= status_i.lookup_hit ? ST_FETCH : ST_FINISH;
        end
        ST_FETCH: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = m_valid_q;

  `IRT_ASSERT_NEXT(a_accept_starts_scan, clk_i, rst_ni, in_fire,
                   (state_q == ST_SCAN) && (cnt_q == '0))
  `IRT_ASSERT_NOW(a_cnt_idle_outside_scan, clk_i, rst_ni, state_q != ST_SCAN, cnt_q == '0)
  `IRT_ASSERT_NOW(a_result_from_finish, clk_i, rst_ni, $rose(m_valid_q),
                  $past(state_q == ST_FINISH))

endmodule

`default_nettype wire

>>> src/ip_route_table.sv
// ip route table top level: stream ports, controller and datapath
// depends on irt_pkg, irt_ctrl and irt_datapath
//
// usage:
//   one request transaction on the s_axis side gives exactly one result
//   transaction on the m_axis side. tuser carries the action on input and
//   the status code on output; tdata carries the route words.
//   each request walks all TABLE_DEPTH entries of the table through one
//   registered memory read port, one entry per cycle, then resolves the
//   update, remove or lookup. a lookup that hits reads the matched entry
//   back in a fetch step. tready comes back with the result, and the next
//   request is not taken before then, so requests are handled one at a
//   time up to the output register.
//   reset empties the table (all valid bits clear) and drops any pending
//   result; no clearing pass is needed.
//   a stalled receiver leaves the result in the output register; the next
//   request is still accepted and scanned, and only its hand-off waits
//   until the previous result transaction completes.
`default_nettype none

module ip_route_table (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [127:0] s_axis_tdata_i,   // net_addr, net_mask, iface_addr, route_data
  input  wire logic [1:0]   s_axis_tuser_i,   // action
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [127:0]      m_axis_tdata_o,   // found_network, found_mask, found_iface, found_data
  output logic [1:0]        m_axis_tuser_o    // status
);

  irt_pkg::dp_cmd_t    cmd;
  irt_pkg::dp_status_t dp_status;
  irt_pkg::status_e    res_status;
  irt_pkg::route_t     res_route;

  // sequencer: handshakes and scan counter
  irt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .cmd_o      (cmd),
    .status_i   (dp_status)
  );

  // table, comparators and result register
  irt_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (dp_status),
    .req_action_i (irt_pkg::action_e'(s_axis_tuser_i)),
    .req_net_i    (s_axis_tdata_i[31:0]),
    .req_mask_i   (s_axis_tdata_i[63:32]),
    .req_iface_i  (s_axis_tdata_i[95:64]),
    .req_data_i   (s_axis_tdata_i[127:96]),
    .res_status_o (res_status),
    .res_route_o  (res_route)
  );

  // route_t packs network in the low word, data in the high word
  assign m_axis_tdata_o = res_route;
  assign m_axis_tuser_o = res_status;

endmodule

`default_nettype wire

>>> sim/tb_ip_route_table.sv
// testbench for ip_route_table: directed rows, then phased random route traffic
// depends on irt_pkg and ip_route_table; shadow table predicts every result not given in a directed row
`timescale 1ns / 1ps

module tb_ip_route_table;

  localparam int unsigned RANDOM_ITEMS   = 720;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 40;   // idle tail after the last result
  localparam int unsigned POOL_SIZE      = 24;   // more networks than slots, so the table fills
  localparam int unsigned IFACE_COUNT    = 6;    // few interfaces, so interface ties happen

  typedef struct packed {
    irt_pkg::action_e act;
    irt_pkg::route_t  route;   // network field carries net_addr, iface field iface_addr
  } route_req_t;

  typedef struct packed {
    irt_pkg::status_e status;
    irt_pkg::route_t  route;
  } route_result_t;

  typedef struct {
    route_req_t    req;
    bit            typed;   // compare against res below instead of the shadow table
    route_result_t res;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [127:0] s_axis_tdata_i = '0;   // net_addr, net_mask, iface_addr, route_data
  logic [1:0]   s_axis_tuser_i = '0;   // action
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [127:0] m_axis_tdata_o;        // found_network, found_mask, found_iface, found_data
  logic [1:0]   m_axis_tuser_o;        // status

  // shadow copy of the route table
  bit              shadow_valid [irt_pkg::TABLE_DEPTH];
  irt_pkg::route_t shadow_route [irt_pkg::TABLE_DEPTH];

  route_result_t  pending_results [$];
  dir_row_t       dir_rows [$];
  irt_pkg::word_t pool_net [POOL_SIZE];
  irt_pkg::word_t pool_mask [POOL_SIZE];
  irt_pkg::word_t iface_pool [IFACE_COUNT];

  int unsigned error_count = 0;
  int unsigned result_count = 0;
  int unsigned reqs_sent = 0;
  int unsigned idle_cycles = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;

  ip_route_table DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow table
  // ---------------------------------------------------------------------------

  function automatic int find_network(irt_pkg::word_t net);
    for (int i = 0; i < irt_pkg::TABLE_DEPTH; i++) begin
      if (shadow_valid[i] && shadow_route[i].network == net) return i;
    end
    return -1;
  endfunction

  function automatic int find_free();
    for (int i = 0; i < irt_pkg::TABLE_DEPTH; i++) begin
      if (!shadow_valid[i]) return i;
    end
    return -1;
  endfunction

  // applies one request to the shadow table and returns the result it gives
  function automatic route_result_t route_table_step(route_req_t req);
    route_result_t res;
    int            slot;
    int            hit;
    res = '0;
    res.status = irt_pkg::STAT_OK;
    hit = -1;
    case (req.act)
      irt_pkg::ACT_UPDATE: begin
        slot = find_network(req.route.network);
        if (slot < 0) slot = find_free();
        if (slot < 0) begin
          res.status = irt_pkg::STAT_FULL;
        end else begin
          shadow_valid[slot] = 1'b1;
          shadow_route[slot] = req.route;
        end
      end
      irt_pkg::ACT_REMOVE: begin
        slot = find_network(req.route.network);
        if (slot < 0) res.status = irt_pkg::STAT_NOT_FOUND;
        else shadow_valid[slot] = 1'b0;
      end
      irt_pkg::ACT_LOOKUP_NET: begin
        // exact network first, then smallest masked match, then default route
        hit = find_network(req.route.network);
        if (hit < 0) begin
          for (int i = 0; i < irt_pkg::TABLE_DEPTH; i++) begin
            if (shadow_valid[i]
                && shadow_route[i].network == (req.route.network & shadow_route[i].mask)
                && (hit < 0 || shadow_route[i].network < shadow_route[hit].network)) begin
              hit = i;
            end
          end
        end
        if (hit < 0) hit = find_network('0);
        if (hit < 0) res.status = irt_pkg::STAT_NOT_FOUND;
      end
      default: begin
        for (int i = 0; i < irt_pkg::TABLE_DEPTH; i++) begin
          if (shadow_valid[i] && shadow_route[i].iface == req.route.iface
              && (hit < 0 || shadow_route[i].network < shadow_route[hit].network)) begin
            hit = i;
          end
        end
        if (hit < 0) res.status = irt_pkg::STAT_NOT_FOUND;
      end
    endcase
    if (hit >= 0) res.route = shadow_route[hit];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic route_req_t make_req(irt_pkg::action_e act, irt_pkg::word_t net,
                                          irt_pkg::word_t mask, irt_pkg::word_t iface,
                                          irt_pkg::word_t data);
    route_req_t req;
    req.act = act;
    req.route.network = net;
    req.route.mask = mask;
    req.route.iface = iface;
    req.route.data = data;
    return req;
  endfunction

  function automatic void add_row(irt_pkg::action_e act, irt_pkg::word_t net,
                                  irt_pkg::word_t mask, irt_pkg::word_t iface,
                                  irt_pkg::word_t data, bit typed, irt_pkg::status_e st,
                                  irt_pkg::word_t fnet, irt_pkg::word_t fmask,
                                  irt_pkg::word_t fiface, irt_pkg::word_t fdata);
    dir_row_t row;
    row.req = make_req(act, net, mask, iface, data);
    row.typed = typed;
    row.res.status = st;
    row.res.route.network = fnet;
    row.res.route.mask = fmask;
    row.res.route.iface = fiface;
    row.res.route.data = fdata;
    dir_rows.push_back(row);
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // prefix masks of varied length with a sprinkle of odd masks; some default routes
  task automatic new_pool();
    int unsigned plen;
    for (int k = 0; k < POOL_SIZE; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        pool_mask[k] = $urandom();
      end else begin
        plen = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(8, 32);
        pool_mask[k] = 32'hFFFF_FFFF << (32 - plen);
      end
      pool_net[k] = $urandom() & pool_mask[k];
    end
    for (int k = 0; k < IFACE_COUNT; k++) iface_pool[k] = $urandom();
  endtask

  // called at a clock edge; leaves tvalid high after the accepting edge
  task automatic send_req(route_req_t req, bit typed, route_result_t typed_res);
    int unsigned   gap;
    route_result_t predicted;
    gap = (!tx_steady && $urandom_range(0, 99) < 40) ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= req.route;
    s_axis_tuser_i  <= req.act;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = route_table_step(req);
    pending_results.push_back(typed ? typed_res : predicted);
    reqs_sent++;
  endtask

  // hold the sender until every outstanding result has come back
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic send_random(route_req_t req);
    send_req(req, 1'b0, '0);
  endtask

  task automatic mix_phase(int unsigned count);
    int unsigned    r;
    int unsigned    k;
    irt_pkg::word_t addr;
    repeat (count) begin
      r = $urandom_range(0, 99);
      k = $urandom_range(0, POOL_SIZE - 1);
      if (r < 35) begin
        send_random(make_req(irt_pkg::ACT_UPDATE, pool_net[k], pool_mask[k],
                             iface_pool[$urandom_range(0, IFACE_COUNT - 1)], $urandom()));
      end else if (r < 50) begin
        addr = ($urandom_range(0, 9) == 0) ? $urandom() : pool_net[k];
        send_random(make_req(irt_pkg::ACT_REMOVE, addr, $urandom(), $urandom(), $urandom()));
      end else if (r < 85) begin
        // an address inside a pool network, with random host bits
        addr = pool_net[k] | ($urandom() & ~pool_mask[k]);
        if ($urandom_range(0, 9) == 0) addr = $urandom();
        send_random(make_req(irt_pkg::ACT_LOOKUP_NET, addr, $urandom(), $urandom(),
                             $urandom()));
      end else begin
        addr = ($urandom_range(0, 9) == 0) ? $urandom()
                                           : iface_pool[$urandom_range(0, IFACE_COUNT - 1)];
        send_random(make_req(irt_pkg::ACT_LOOKUP_IFACE, $urandom(), $urandom(), addr,
                             $urandom()));
      end
    end
  endtask

  // walks the pool with updates, well past the point where the table is full
  task automatic fill_phase();
    int unsigned k;
    k = $urandom_range(0, POOL_SIZE - 1);
    repeat (20) begin
      send_random(make_req(irt_pkg::ACT_UPDATE, pool_net[k], pool_mask[k],
                           iface_pool[$urandom_range(0, IFACE_COUNT - 1)], $urandom()));
      k = (k + 1) % POOL_SIZE;
    end
  endtask

  // removes everything the table holds, plus one random network, then draws a new pool
  task automatic clear_phase();
    irt_pkg::word_t nets [$];
    for (int i = 0; i < irt_pkg::TABLE_DEPTH; i++) begin
      if (shadow_valid[i]) nets.push_back(shadow_route[i].network);
    end
    nets.shuffle();
    nets.push_back($urandom());
    foreach (nets[i]) begin
      send_random(make_req(irt_pkg::ACT_REMOVE, nets[i], $urandom(), $urandom(), $urandom()));
    end
    new_pool();
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_error(string msg);
    $display("[%0t] result %0d: %s", $time, result_count, msg);
    error_count++;
  endtask

  task automatic check_field(string name, irt_pkg::word_t got, irt_pkg::word_t want);
    if (got !== want) report_error($sformatf("%s got %h expected %h", name, got, want));
  endtask

  task automatic check_result();
    route_result_t   want;
    irt_pkg::route_t got;
    got = m_axis_tdata_o;
    if (pending_results.size() == 0) begin
      report_error("result with no request outstanding");
    end else begin
      want = pending_results.pop_front();
      check_field("status", irt_pkg::word_t'(m_axis_tuser_o), irt_pkg::word_t'(want.status));
      check_field("found_network", got.network, want.route.network);
      check_field("found_mask", got.mask, want.route.mask);
      check_field("found_iface", got.iface, want.route.iface);
      check_field("found_data", got.data, want.route.data);
    end
    result_count++;
  endtask

  // receiver: checks each result transaction, stalls at random
  initial begin
    int unsigned rx_hold;
    rx_hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) check_result();
      if (rx_hold > 0) rx_hold--;
      else if (!rx_steady && $urandom_range(0, 99) < 30) rx_hold = pick_gap();
      m_axis_tready_i <= (rx_hold == 0);
    end
  end

  // watchdog: too long without any transaction ends the run
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("** ip_route_table: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned random_start;
    int unsigned phase_no;
    int unsigned kind;

    // empty table: every miss case
    add_row(irt_pkg::ACT_LOOKUP_NET, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0, 32'hFFFF_FFFF,
            1, irt_pkg::STAT_NOT_FOUND, 0, 0, 0, 0);
    add_row(irt_pkg::ACT_LOOKUP_IFACE, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0,
            1, irt_pkg::STAT_NOT_FOUND, 0, 0, 0, 0);
    add_row(irt_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0,
            1, irt_pkg::STAT_NOT_FOUND, 0, 0, 0, 0);
    // all-ones route, found by exact network and by interface
    add_row(irt_pkg::ACT_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            1, irt_pkg::STAT_OK, 0, 0, 0, 0);
    add_row(irt_pkg::ACT_LOOKUP_NET, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
            1, irt_pkg::STAT_OK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_row(irt_pkg::ACT_LOOKUP_IFACE, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0,
            1, irt_pkg::STAT_OK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // two nested prefixes on one interface
    add_row(irt_pkg::ACT_UPDATE, 32'h0A00_0000, 32'hFF00_0000, 32'hC0A8_0001, 32'h1234_5678,
            1, irt_pkg::STAT_OK, 0, 0, 0, 0);
    add_row(irt_pkg::ACT_UPDATE, 32'h0A01_0000, 32'hFFFF_0000, 32'hC0A8_0001, 32'h9ABC_DEF0,
            1, irt_pkg::STAT_OK, 0, 0, 0, 0);
    add_row(irt_pkg::ACT_LOOKUP_NET, 32'h0A01_0203, 32'h0, 32'h0, 32'h0,
            0, irt_pkg::STAT_OK, 0, 0, 0, 0);
    add_row(irt_pkg::ACT_LOOKUP_NET, 32'h0A01_0000, 32'h0, 32'h0, 32'h0,
            0, irt_pkg::STAT_OK, 0, 0, 0, 0);
    add_row(irt_pkg::ACT_LOOKUP_IFACE, 32'h0, 32'h0, 32'hC0A8_0001, 32'h0,
            0, irt_pkg::STAT_OK, 0, 0, 0, 0);
    // no match and no default route
    add_row(irt_pkg::ACT_LOOKUP_NET, 32'h0B00_0001, 32'h0, 32'h0, 32'h0,
            1, irt_pkg::STAT_NOT_FOUND, 0, 0, 0, 0);
    // default route, then replace an existing network
    add_row(irt_pkg::ACT_UPDATE, 32'h0, 32'h0, 32'h0101_0101, 32'h5A5A_5A5A,
            1, irt_pkg::STAT_OK, 0, 0, 0, 0);
    add_row(irt_pkg::ACT_LOOKUP_NET, 32'h0B00_0001, 32'h0, 32'h0, 32'h0,
            0, irt_pkg::STAT_OK, 0, 0, 0, 0);
    add_row(irt_pkg::ACT_UPDATE, 32'h0A00_0000, 32'hFFFF_FF00, 32'h0A0A_0A0A, 32'hA5A5_A5A5,
            1, irt_pkg::STAT_OK, 0, 0, 0, 0);
    add_row(irt_pkg::ACT_LOOKUP_NET, 32'h0A00_0077, 32'h0, 32'h0, 32'h0,
            0, irt_pkg::STAT_OK, 0, 0, 0, 0);
    // remove the default route twice
    add_row(irt_pkg::ACT_REMOVE, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0,
            1, irt_pkg::STAT_OK, 0, 0, 0, 0);
    add_row(irt_pkg::ACT_REMOVE, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF,
            1, irt_pkg::STAT_NOT_FOUND, 0, 0, 0, 0);
    add_row(irt_pkg::ACT_LOOKUP_NET, 32'h0B00_0001, 32'h0, 32'h0, 32'h0,
            1, irt_pkg::STAT_NOT_FOUND, 0, 0, 0, 0);
    // non-contiguous mask
    add_row(irt_pkg::ACT_UPDATE, 32'h00FF_00FF, 32'h00FF_00FF, 32'h0F0F_0F0F, 32'h0,
            1, irt_pkg::STAT_OK, 0, 0, 0, 0);
    add_row(irt_pkg::ACT_LOOKUP_NET, 32'h12FF_34FF, 32'h0, 32'h0, 32'h0,
            0, irt_pkg::STAT_OK, 0, 0, 0, 0);
    add_row(irt_pkg::ACT_LOOKUP_IFACE, 32'h0, 32'h0, 32'h0F0F_0F0F, 32'h0,
            0, irt_pkg::STAT_OK, 0, 0, 0, 0);
    add_row(irt_pkg::ACT_LOOKUP_IFACE, 32'h0, 32'h0, 32'hC0A8_0001, 32'h0,
            0, irt_pkg::STAT_OK, 0, 0, 0, 0);
    add_row(irt_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
            1, irt_pkg::STAT_OK, 0, 0, 0, 0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

    // random part: fill, mixed traffic and clearing phases over a shared pool
    new_pool();
    random_start = reqs_sent;
    phase_no = 0;
    while (reqs_sent - random_start < RANDOM_ITEMS) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      kind = (phase_no == 0) ? 0 : $urandom_range(0, 9);
      if (kind < 3) fill_phase();
      else if (kind < 8) mix_phase(30);
      else clear_phase();
      if (phase_no == 0 || $urandom_range(0, 3) == 0) drain_results();
      phase_no++;
    end

    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("** ip_route_table: PASSED **");
    end else begin
      $display("** ip_route_table: FAILED **");
    end
    $finish;
  end

endmodule

>>> ip_route_table.f
+incdir+src
src/irt_pkg.sv
src/irt_datapath.sv
src/irt_ctrl.sv
src/ip_route_table.sv
sim/tb_ip_route_table.sv
